FILE: rtl/core/amq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amq_pkg;

    localparam int OUT_CNT_W = 7;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TAKE   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // commit kinds, controller to datapath
    localparam logic [1:0] CM_FULL  = 2'd0;
    localparam logic [1:0] CM_PLACE = 2'd1;
    localparam logic [1:0] CM_EMPTY = 2'd2;
    localparam logic [1:0] CM_POP   = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] alarm_time;
        logic [4:0]  alarm_day;
        logic [4:0]  alarm_hour;
        logic [31:0] current_time;
    } amq_in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [31:0]          out_time;
        logic [4:0]           out_day;
        logic [4:0]           out_hour;
        logic [OUT_CNT_W-1:0] expired_dropped;
        logic [OUT_CNT_W-1:0] entries_left;
    } amq_out_t;

    typedef struct packed {
        logic [31:0] time_s;
        logic [4:0]  day;
        logic [4:0]  hour;
    } amq_entry_t;

    typedef struct packed {
        logic       load;
        logic       ins_rd;
        logic       take_rd;
        logic       shift;
        logic       skip;
        logic       commit;
        logic [1:0] kind;
    } amq_cmd_t;

    typedef struct packed {
        logic is_take;
        logic full;
        logic off_zero;
        logic off_one;
        logic off_eq_cnt;
        logic rd_gt;
        logic rd_lt;
        logic out_free;
    } amq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/amq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface amq_in_if;
    import amq_pkg::*;

    logic    valid;
    logic    ready;
    amq_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface amq_out_if;
    import amq_pkg::*;

    logic     valid;
    logic     ready;
    amq_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/alarm_min_priority_queue_unit.sv
// Insert runs a shift loop that compares stored entries and moves later ones up; take
//   scans and skips expired entries, then pops the next one or reports empty.
// Insert into a full or empty store and take from an empty store skip the loop. A stalled
//   far side holds the commit. One item in flight at a time: the next item is
//   accepted the cycle after the result registers.
// Reset (async, active low) empties the store at once; entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module alarm_min_priority_queue_unit
    import amq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    amq_in_if.sink     req,
    amq_out_if.source  rsp
);

    // controller and datapath talk only through these two bundles
    amq_cmd_t  cmd;
    amq_stat_t stat;

    // Controller: sequences the sorted-insert shift loop (read, compare,
    // move one entry up) and the expiry scan (read, compare, skip), then
    // commits the item once the result register is free.
    amq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: circular entry memory (head + count), one write and one
    // registered read port per cycle, scan offset, and the result register
    // that holds an item while the far side stalls.
    amq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/amq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module amq_ctrl
    import amq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire amq_stat_t stat,
    output amq_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_INS_RD   = 3'd2;
    localparam logic [2:0] S_INS_CMP  = 3'd3;
    localparam logic [2:0] S_TAKE_RD  = 3'd4;
    localparam logic [2:0] S_TAKE_CMP = 3'd5;
    localparam logic [2:0] S_TAKE_CHK = 3'd6;
    localparam logic [2:0] S_COMMIT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= CM_FULL;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.kind    = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_take)
                begin
                    if (stat.off_eq_cnt)
                    begin
                        kind_next  = CM_EMPTY;
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_TAKE_RD;
                    end
                end
                else if (stat.full)
                begin
                    kind_next  = CM_FULL;
                    state_next = S_COMMIT;
                end
                else if (stat.off_zero)
                begin
                    kind_next  = CM_PLACE;
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                cmd.ins_rd = 1'b1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (stat.rd_gt)
                begin
                    cmd.shift = 1'b1;
                    if (stat.off_one)
                    begin
                        kind_next  = CM_PLACE;
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    kind_next  = CM_PLACE;
                    state_next = S_COMMIT;
                end
            end
            S_TAKE_RD:
            begin
                cmd.take_rd = 1'b1;
                state_next  = S_TAKE_CMP;
            end
            S_TAKE_CMP:
            begin
                if (stat.rd_lt)
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_TAKE_CHK;
                end
                else
                begin
                    kind_next  = CM_POP;
                    state_next = S_COMMIT;
                end
            end
            S_TAKE_CHK:
            begin
                if (stat.off_eq_cnt)
                begin
                    kind_next  = CM_EMPTY;
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_TAKE_RD;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/amq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module amq_datapath
    import amq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire amq_in_t  in_data,
    input  wire amq_cmd_t cmd,
    output amq_stat_t     stat,
    output logic          out_valid,
    input  wire logic     out_ready,
    output amq_out_t      out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    amq_entry_t mem [CAPACITY];

    amq_in_t    item_reg;
    amq_entry_t rdata_reg;
    amq_out_t   out_reg;
    amq_out_t   out_next;
    logic       out_valid_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] off_reg;

    logic [CW-1:0] off_m1, off_p1, count_after;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    amq_entry_t    wdata, new_entry;

    // circular index, base plus offset modulo CAPACITY
    function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                               input logic [CW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(ofs);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign off_m1 = off_reg - CW'(1);
    assign off_p1 = off_reg + CW'(1);
    assign count_after = count_reg - off_p1;

    assign new_entry.time_s = item_reg.alarm_time;
    assign new_entry.day    = item_reg.alarm_day;
    assign new_entry.hour   = item_reg.alarm_hour;

    assign raddr = cmd.ins_rd ? wrap_idx(head_reg, off_m1) : wrap_idx(head_reg, off_reg);
    assign waddr = wrap_idx(head_reg, off_reg);
    assign we    = cmd.shift || (cmd.commit && (cmd.kind == CM_PLACE));
    assign wdata = cmd.shift ? rdata_reg : new_entry;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.ins_rd || cmd.take_rd)
        begin
            rdata_reg <= mem[raddr];
        end
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            off_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                off_reg <= (in_data.action == ACT_TAKE) ? '0 : count_reg;
            end
            else if (cmd.shift)
            begin
                off_reg <= off_m1;
            end
            else if (cmd.skip)
            begin
                off_reg <= off_p1;
            end
            if (cmd.commit)
            begin
                case (cmd.kind)
                    CM_PLACE: count_reg <= count_reg + CW'(1);
                    CM_EMPTY: count_reg <= '0;
                    CM_POP:
                    begin
                        count_reg <= count_after;
                        head_reg  <= wrap_idx(head_reg, off_p1);
                    end
                    default: count_reg <= count_reg;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_next = '0;
        case (cmd.kind)
            CM_FULL:
            begin
                out_next.status       = ST_FULL;
                out_next.entries_left = OUT_CNT_W'(count_reg);
            end
            CM_PLACE:
            begin
                out_next.status       = ST_OK;
                out_next.entries_left = OUT_CNT_W'(count_reg + CW'(1));
            end
            CM_EMPTY:
            begin
                out_next.status          = ST_EMPTY;
                out_next.expired_dropped = OUT_CNT_W'(off_reg);
            end
            CM_POP:
            begin
                out_next.status          = ST_OK;
                out_next.out_time        = rdata_reg.time_s;
                out_next.out_day         = rdata_reg.day;
                out_next.out_hour        = rdata_reg.hour;
                out_next.expired_dropped = OUT_CNT_W'(off_reg);
                out_next.entries_left    = OUT_CNT_W'(count_after);
            end
            default: out_next.status = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign stat.is_take    = (item_reg.action == ACT_TAKE);
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.off_zero   = (off_reg == '0);
    assign stat.off_one    = (off_reg == CW'(1));
    assign stat.off_eq_cnt = (off_reg == count_reg);
    assign stat.rd_gt      = (rdata_reg.time_s > item_reg.alarm_time);
    assign stat.rd_lt      = (rdata_reg.time_s < item_reg.current_time);
    assign stat.out_free   = !out_valid_reg || out_ready;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_off_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins_rd || cmd.take_rd) |-> (off_reg <= count_reg))
        else $error("scan offset beyond stored entries");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (cmd.kind == CM_POP)) |-> (count_reg != '0))
        else $error("pop from empty store");

    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (cmd.kind == CM_PLACE)) |=> (count_reg != '0))
        else $error("place left store empty");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// Alarm queue testbench: sorted insert, expiry on take, full and empty reports.
// Every accepted request is run through a queue-based predictor at the same
// edge. Each response is then checked against the oldest prediction.
module testbench;
    import amq_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 4_000_000;
    // Idle wait after the last test for any late or extra response.
    localparam int SETTLE      = 200;
    localparam int CHUNK       = 50;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    amq_in_if  req ();
    amq_out_if rsp ();

    alarm_min_priority_queue_unit #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: the queue below mirrors the stored alarms.
    // They are kept earliest first, and equal stamps stay in arrival order.
    // ------------------------------------------------------------------
    amq_entry_t  alarm_model[$];
    amq_out_t    expected_results[$];

    bit          calm       = 1'b0;     // final stretch: no idling on either side
    bit          idle_on    = 1'b1;     // per-chunk switch for random idling
    int          hold_left  = 0;        // long receiver hold-off, counted in the ready process
    int          stall_left = 0;
    logic [31:0] wall_s;                // running "now" that random items are built around

    int fail_count  = 0;
    int cycle_count = 0;
    int n_insert    = 0;
    int n_take      = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int n_dropped   = 0;
    int peak_level  = 0;

    // Work out the response to one request and update the mirrored store.
    function automatic amq_out_t predict_alarm(input amq_in_t item);
        amq_out_t   r;
        amq_entry_t e;
        int         pos;
        int         gone;
        r = '0;
        r.status = ST_OK;
        if (item.action == ACT_INSERT) begin
            n_insert++;
            if (alarm_model.size() >= CAPACITY) begin
                // Store is full: the new alarm is dropped and the store is unchanged.
                r.status = ST_FULL;
                n_full++;
            end
            else begin
                // The new alarm goes after every entry with an equal or earlier stamp.
                pos = alarm_model.size();
                while (pos > 0 && alarm_model[pos - 1].time_s > item.alarm_time)
                    pos--;
                e.time_s = item.alarm_time;
                e.day    = item.alarm_day;
                e.hour   = item.alarm_hour;
                alarm_model.insert(pos, e);
            end
        end
        else begin
            n_take++;
            // An entry expires only when its stamp is strictly below now.
            gone = 0;
            while (alarm_model.size() > 0 && alarm_model[0].time_s < item.current_time) begin
                void'(alarm_model.pop_front());
                gone++;
            end
            r.expired_dropped = gone[OUT_CNT_W-1:0];
            n_dropped += gone;
            if (alarm_model.size() == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else begin
                e          = alarm_model.pop_front();
                r.out_time = e.time_s;
                r.out_day  = e.day;
                r.out_hour = e.hour;
            end
        end
        r.entries_left = OUT_CNT_W'(alarm_model.size());
        if (alarm_model.size() > peak_level)
            peak_level = alarm_model.size();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Requests are predicted before responses are checked on the same edge.
    // A response therefore always meets the prediction for its own item.
    always @(posedge clk) begin : scoreboard
        amq_out_t want;
        if (rst_n && req.valid && req.ready)
            expected_results.push_back(predict_alarm(req.data));
        if (rst_n && rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
                $error("response with no item outstanding: %p", rsp.data);
                fail_count++;
            end
            else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.data.status));
                check_field("out_time", want.out_time, rsp.data.out_time);
                check_field("out_day", 32'(want.out_day), 32'(rsp.data.out_day));
                check_field("out_hour", 32'(want.out_hour), 32'(rsp.data.out_hour));
                check_field("expired_dropped", 32'(want.expired_dropped),
                            32'(rsp.data.expired_dropped));
                check_field("entries_left", 32'(want.entries_left),
                            32'(rsp.data.entries_left));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Response side: a long hold when asked, otherwise short random stalls.
    // Only one value is assigned per falling edge.
    initial begin : ready_drive
        rsp.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                rsp.ready <= 1'b0;
            end
            else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Valid stays high straight into the next item unless a gap lowers it.
    task automatic send_item(input amq_in_t item);
        @(negedge clk);
        req.valid <= 1'b1;
        req.data  <= item;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 16);
        if (calm || !idle_on || $urandom_range(0, 5) != 0)
            return;
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // The fields an item does not use get random values, so their bits toggle too.
    function automatic amq_in_t insert_item(input logic [31:0] t, input logic [4:0] d,
                                            input logic [4:0] h);
        amq_in_t it;
        it.action       = ACT_INSERT;
        it.alarm_time   = t;
        it.alarm_day    = d;
        it.alarm_hour   = h;
        it.current_time = $urandom;
        return it;
    endfunction

    function automatic amq_in_t take_item(input logic [31:0] now);
        amq_in_t it;
        it.action       = ACT_TAKE;
        it.alarm_time   = $urandom;
        it.alarm_day    = 5'($urandom_range(0, 31));
        it.alarm_hour   = 5'($urandom_range(0, 31));
        it.current_time = now;
        return it;
    endfunction

    // Stamps cluster just ahead of a clock that advances on most takes.
    // Takes then expire a few entries at a time, with occasional far-out noise.
    function automatic amq_in_t random_item(input int insert_pct);
        logic [31:0] t;
        logic [4:0]  d;
        logic [4:0]  h;
        d = 5'($urandom_range(1, 31));
        h = 5'($urandom_range(0, 23));
        if ($urandom_range(0, 15) == 0) begin
            d = 5'($urandom_range(0, 31));
            h = 5'($urandom_range(0, 31));
        end
        if ($urandom_range(0, 99) < insert_pct) begin
            case ($urandom_range(0, 9))
                0:       t = $urandom;
                1:       t = wall_s;
                default: t = wall_s + $urandom_range(0, 120);
            endcase
            return insert_item(t, d, h);
        end
        if ($urandom_range(0, 39) == 0)
            return take_item($urandom);
        wall_s = wall_s + $urandom_range(0, 30);
        return take_item(wall_s);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_item(take_item(32'd0));                          // take from empty store
        send_item(insert_item(32'hFFFF_FFFF, 5'd31, 5'd31));  // top stamp, hour out of range
        send_item(insert_item(32'd0, 5'd0, 5'd0));            // bottom stamp
        send_item(insert_item(32'd1000, 5'd1, 5'd0));         // three equal stamps: FIFO order
        send_item(insert_item(32'd1000, 5'd2, 5'd1));
        send_item(insert_item(32'd1000, 5'd3, 5'd23));
        send_item(insert_item(32'h8000_0000, 5'd15, 5'd16));
        send_item(take_item(32'd0));                          // stamp equal to now is kept
        send_item(take_item(32'd1000));                       // oldest of the equal stamps
        send_item(take_item(32'd1001));                       // the other two expire
        send_item(take_item(32'hFFFF_FFFF));                  // top stamp survives top now
        send_item(take_item(32'hFFFF_FFFF));                  // empty again
        send_item(insert_item(32'd5, 5'd4, 5'd5));
        send_item(insert_item(32'd6, 5'd5, 5'd6));
        send_item(insert_item(32'd7, 5'd6, 5'd7));
        send_item(take_item(32'd100));                        // all expire, reports empty
        send_item(insert_item(32'hAAAA_AAAA, 5'd10, 5'd21));
        send_item(insert_item(32'h5555_5555, 5'd21, 5'd10));
        send_item(take_item(32'h5555_5556));                  // one expires, next returned
        send_item(take_item(32'd0));
        wait_drained();
    endtask

    // Fill to capacity, push past it, then expire the whole store in one take.
    // Then refill with many duplicate stamps and read it all back in order.
    task automatic test_fill_full();
        int room;
        room = CAPACITY - alarm_model.size();
        for (int i = 0; i < room + 3; i++) begin
            send_item(insert_item($urandom_range(0, 5000), 5'($urandom_range(1, 31)),
                                  5'($urandom_range(0, 23))));
            sender_gap();
        end
        send_item(take_item(32'hFFFF_FFFF));
        for (int i = 0; i < CAPACITY; i++) begin
            send_item(insert_item($urandom_range(0, 20), 5'($urandom_range(1, 31)),
                                  5'($urandom_range(0, 23))));
            sender_gap();
        end
        for (int i = 0; i <= CAPACITY; i++) begin
            send_item(take_item(32'd0));
            sender_gap();
        end
        wait_drained();
    endtask

    // The receiver holds off for a long time while items keep coming.
    // The single-item block must then stall its request side.
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2)
                send_item(take_item(wall_s));
            else
                send_item(insert_item(wall_s + $urandom_range(0, 50),
                                      5'($urandom_range(1, 31)),
                                      5'($urandom_range(0, 23))));
        end
        wait_drained();
    endtask

    // Chunks differ in insert/take mix and idling. Some start next to the 32-bit wrap.
    // Halfway through, the sender pauses until every response has arrived.
    task automatic test_random(input int chunks);
        int insert_pct;
        for (int c = 0; c < chunks; c++) begin
            idle_on    = ($urandom_range(0, 3) != 0);
            insert_pct = 30 + 20 * $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                wall_s = 32'hFFFF_FFFF - $urandom_range(0, 300);
            for (int i = 0; i < CHUNK; i++) begin
                send_item(random_item(insert_pct));
                sender_gap();
            end
            if (c == chunks / 2)
                wait_drained();
        end
    endtask

    task automatic test_calm();
        calm       = 1'b1;
        stall_left = 0;
        for (int i = 0; i < 100; i++)
            send_item(random_item(50));
        wait_drained();
    endtask

    initial begin : main
        req.valid = 1'b0;
        req.data  = '0;
        wall_s    = $urandom;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fill_full();
        test_backpressure();
        test_random(24);
        test_calm();

        // Any late or extra response shows up in the scoreboard here.
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d inserts (%0d refused full) and %0d takes (%0d empty)",
                 n_insert, n_full, n_take, n_empty);
        $display("%0d alarms expired on take, store peaked at %0d of %0d",
                 n_dropped, peak_level, CAPACITY);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
